[rtl/bdel_pkg.sv]
// ----------------------------------------------------------------------------
// bdel_pkg
// shared types and constants for the button debounce and event latch block
// ----------------------------------------------------------------------------
package bdel_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int HISTORY_LEN_DEF = 8;
    localparam int OP_W            = 2;
    localparam int BUZZ_W          = 16;
    localparam int TICK_W          = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_CONSUME = 2'd1,
        OP_BUZZ    = 2'd2
    } op_t;

    // decoded command of one accepted transfer
    typedef struct packed {
        logic accept;
        logic tick;
        logic consume;
        logic buzz;
    } bdel_cmd_t;

endpackage

[rtl/bdel_if.sv]
// ----------------------------------------------------------------------------
// bdel_req_if / bdel_rsp_if
// valid/ready channels carrying request items and result items
// ----------------------------------------------------------------------------
interface bdel_req_if #(
    parameter int NUM_BUTTONS = bdel_pkg::NUM_BUTTONS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [bdel_pkg::OP_W-1:0]   op;
    logic [NUM_BUTTONS-1:0]      button_levels;
    logic [NUM_BUTTONS-1:0]      consume_mask;
    logic [bdel_pkg::BUZZ_W-1:0] buzz_ms;

    modport source (output valid, op, button_levels, consume_mask, buzz_ms, input ready);
    modport sink   (input valid, op, button_levels, consume_mask, buzz_ms, output ready);
endinterface

interface bdel_rsp_if #(
    parameter int NUM_BUTTONS = bdel_pkg::NUM_BUTTONS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [NUM_BUTTONS-1:0]      debounced_state;
    logic [NUM_BUTTONS-1:0]      pending_events;
    logic                        consume_hit;
    logic                        buzzer_on;
    logic [bdel_pkg::TICK_W-1:0] tick_count;

    modport source (output valid, debounced_state, pending_events, consume_hit, buzzer_on,
                    tick_count, input ready);
    modport sink   (input valid, debounced_state, pending_events, consume_hit, buzzer_on,
                    tick_count, output ready);
endinterface

[rtl/bdel_lane.sv]
// ----------------------------------------------------------------------------
// bdel_lane
// one button: sample history shift register and debounced state bit
// ----------------------------------------------------------------------------
module bdel_lane #(
    parameter int HISTORY_LEN = bdel_pkg::HISTORY_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic tick,
    input  logic level,
    output logic stable_q,
    output logic stable_d
);

    logic [HISTORY_LEN-1:0] hist_reg;
    logic [HISTORY_LEN-1:0] hist_next;
    logic                   stable_reg;
    logic                   stable_next;

    always_comb
    begin
        hist_next   = hist_reg;
        stable_next = stable_reg;
        if (tick)
        begin
            hist_next = {hist_reg[HISTORY_LEN-2:0], level};
            if (hist_next == '0)
            begin
                stable_next = 1'b0;
            end
            else if (hist_next == '1)
            begin
                stable_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg   <= '0;
            stable_reg <= 1'b0;
        end
        else
        begin
            hist_reg   <= hist_next;
            stable_reg <= stable_next;
        end
    end

    assign stable_q = stable_reg;
    assign stable_d = stable_next;

    // debounced bit always agrees with a saturated history
    a_full_hist_stable : assert property (@(posedge clk) disable iff (!rst_n)
        hist_reg == '1 |-> stable_reg)
        else $error("history all ones but debounced bit low");

    a_empty_hist_clear : assert property (@(posedge clk) disable iff (!rst_n)
        hist_reg == '0 |-> !stable_reg)
        else $error("history all zeros but debounced bit high");

endmodule

[rtl/bdel_merge.sv]
// ----------------------------------------------------------------------------
// bdel_merge
// combines lane results: event latch, buzzer countdown, tick counter, result register
// ----------------------------------------------------------------------------
module bdel_merge #(
    parameter int NUM_BUTTONS = bdel_pkg::NUM_BUTTONS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bdel_pkg::bdel_cmd_t         cmd,
    input  logic [NUM_BUTTONS-1:0]      consume_mask,
    input  logic [bdel_pkg::BUZZ_W-1:0] buzz_ms,
    input  logic [NUM_BUTTONS-1:0]      stable_q,
    input  logic [NUM_BUTTONS-1:0]      stable_d,
    output logic                        out_free,
    bdel_rsp_if.source                  rsp
);

    logic [NUM_BUTTONS-1:0]      event_reg;
    logic [NUM_BUTTONS-1:0]      event_next;
    logic [bdel_pkg::BUZZ_W-1:0] buzz_remaining_reg;
    logic [bdel_pkg::BUZZ_W-1:0] buzz_remaining_next;
    logic                        buzz_drive_reg;
    logic                        buzz_drive_next;
    logic [bdel_pkg::TICK_W-1:0] tick_count_reg;
    logic [bdel_pkg::TICK_W-1:0] tick_count_next;
    logic                        hit;

    logic                        valid_reg;
    logic                        valid_next;
    logic [NUM_BUTTONS-1:0]      out_state_reg;
    logic [NUM_BUTTONS-1:0]      out_events_reg;
    logic                        out_hit_reg;
    logic                        out_buzz_reg;
    logic [bdel_pkg::TICK_W-1:0] out_tick_reg;

    always_comb
    begin
        event_next          = event_reg;
        buzz_remaining_next = buzz_remaining_reg;
        buzz_drive_next     = buzz_drive_reg;
        tick_count_next     = tick_count_reg;
        hit                 = 1'b0;
        if (cmd.tick)
        begin
            tick_count_next = tick_count_reg + bdel_pkg::TICK_W'(1);
            event_next      = event_reg | (stable_q ^ stable_d);
            if (buzz_remaining_reg != '0)
            begin
                buzz_remaining_next = buzz_remaining_reg - bdel_pkg::BUZZ_W'(1);
                if (buzz_remaining_next == '0)
                begin
                    buzz_drive_next = 1'b0;
                end
            end
        end
        if (cmd.consume)
        begin
            hit        = |(event_reg & consume_mask);
            event_next = event_reg & ~consume_mask;
        end
        if (cmd.buzz)
        begin
            buzz_remaining_next = buzz_ms;
            buzz_drive_next     = (buzz_ms != '0);
        end
    end

    // result register: loads on every accepted transfer, drains when taken
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.accept)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_reg          <= '0;
            buzz_remaining_reg <= '0;
            buzz_drive_reg     <= 1'b0;
            tick_count_reg     <= '0;
            valid_reg          <= 1'b0;
        end
        else
        begin
            event_reg          <= event_next;
            buzz_remaining_reg <= buzz_remaining_next;
            buzz_drive_reg     <= buzz_drive_next;
            tick_count_reg     <= tick_count_next;
            valid_reg          <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            out_state_reg  <= stable_d;
            out_events_reg <= event_next;
            out_hit_reg    <= hit;
            out_buzz_reg   <= buzz_drive_next;
            out_tick_reg   <= tick_count_next;
        end
    end

    assign out_free            = !valid_reg || rsp.ready;
    assign rsp.valid           = valid_reg;
    assign rsp.debounced_state = out_state_reg;
    assign rsp.pending_events  = out_events_reg;
    assign rsp.consume_hit     = out_hit_reg;
    assign rsp.buzzer_on       = out_buzz_reg;
    assign rsp.tick_count      = out_tick_reg;

    a_buzz_has_count : assert property (@(posedge clk) disable iff (!rst_n)
        buzz_drive_reg |-> buzz_remaining_reg != '0)
        else $error("buzzer driven with empty countdown");

    a_consume_clears : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.consume |=> (event_reg & $past(consume_mask)) == '0)
        else $error("consumed event bits still pending");

    a_tick_counts : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tick |=> tick_count_reg == $past(tick_count_reg) + bdel_pkg::TICK_W'(1))
        else $error("tick counter did not advance");

endmodule

[rtl/button_debounce_event_latch.sv]
// ----------------------------------------------------------------------------
// button_debounce_event_latch
// per-button shift-register debounce with event latch, buzzer countdown and tick counter
// ----------------------------------------------------------------------------
// an accepted request transfer has its result on rsp in the cycle after it
// throughput: one item per cycle while req.ready is high; all state updates in the accepting cycle
// the single result register is the only buffer; req.ready is low only while
// a result waits and rsp.ready is low
// reset: asynchronous active-low rst_n clears histories, debounced bits, events,
// countdown, buzzer and tick counter, and empties the result register
module button_debounce_event_latch #(
    parameter int NUM_BUTTONS = bdel_pkg::NUM_BUTTONS_DEF,
    parameter int HISTORY_LEN = bdel_pkg::HISTORY_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bdel_req_if.sink   req,
    bdel_rsp_if.source rsp
);

    bdel_pkg::bdel_cmd_t    cmd;
    logic                   out_free;
    logic [NUM_BUTTONS-1:0] stable_q;
    logic [NUM_BUTTONS-1:0] stable_d;

    // a new request is taken whenever the result register is empty or draining
    assign req.ready = out_free;

    // decode the op of an accepted transfer; the unused code changes no state but still yields a result
    always_comb
    begin
        cmd         = '0;
        cmd.accept  = req.valid && req.ready;
        case (req.op)
            bdel_pkg::OP_TICK:    cmd.tick    = cmd.accept;
            bdel_pkg::OP_CONSUME: cmd.consume = cmd.accept;
            bdel_pkg::OP_BUZZ:    cmd.buzz    = cmd.accept;
            default:              cmd.tick    = 1'b0;
        endcase
    end

    // one debounce lane per button, all shifting on the same tick
    for (genvar b = 0; b < NUM_BUTTONS; b++)
    begin : g_lane
        bdel_lane #(
            .HISTORY_LEN (HISTORY_LEN)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick     (cmd.tick),
            .level    (req.button_levels[b]),
            .stable_q (stable_q[b]),
            .stable_d (stable_d[b])
        );
    end

    // merging stage: event latch from lane edges, buzzer, counter, result register
    bdel_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .consume_mask (req.consume_mask),
        .buzz_ms      (req.buzz_ms),
        .stable_q     (stable_q),
        .stable_d     (stable_d),
        .out_free     (out_free),
        .rsp          (rsp)
    );

endmodule

[bench/button_predict_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_predict_pkg
// transfer types and a self-checking predictor for the debounce block
// ----------------------------------------------------------------------------
package button_predict_pkg;

    localparam int NUM_BTN  = bdel_pkg::NUM_BUTTONS_DEF;
    localparam int HIST_LEN = bdel_pkg::HISTORY_LEN_DEF;

    localparam logic [bdel_pkg::OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam logic [HIST_LEN-1:0]       HIST_FULL  = '1;
    localparam logic [HIST_LEN-1:0]       HIST_EMPTY = '0;

    typedef struct packed {
        logic [bdel_pkg::OP_W-1:0]   op;
        logic [NUM_BTN-1:0]          button_levels;
        logic [NUM_BTN-1:0]          consume_mask;
        logic [bdel_pkg::BUZZ_W-1:0] buzz_ms;
    } req_item_t;

    typedef struct packed {
        logic [NUM_BTN-1:0]          debounced_state;
        logic [NUM_BTN-1:0]          pending_events;
        logic                        consume_hit;
        logic                        buzzer_on;
        logic [bdel_pkg::TICK_W-1:0] tick_count;
    } rsp_item_t;

    class button_state_predictor;
        logic [HIST_LEN-1:0]         history [NUM_BTN];
        logic [NUM_BTN-1:0]          stable_now;
        logic [NUM_BTN-1:0]          stable_last;
        logic [NUM_BTN-1:0]          events;
        logic [bdel_pkg::BUZZ_W-1:0] buzz_left;
        logic                        buzz_drive;
        logic [bdel_pkg::TICK_W-1:0] ticks;
        rsp_item_t                   expected_results[$];
        int                          mismatches;

        function new();
            foreach (history[b])
                history[b] = HIST_EMPTY;
            stable_now  = '0;
            stable_last = '0;
            events      = '0;
            buzz_left   = '0;
            buzz_drive  = 1'b0;
            ticks       = '0;
            mismatches  = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // update the state for one accepted request and queue its result
        function void apply_request(req_item_t it);
            rsp_item_t want;
            logic [HIST_LEN-1:0] h;
            want.consume_hit = 1'b0;
            case (it.op)
                bdel_pkg::OP_TICK:
                begin
                    ticks = ticks + bdel_pkg::TICK_W'(1);
                    for (int b = 0; b < NUM_BTN; b++)
                    begin
                        h = {history[b][HIST_LEN-2:0], it.button_levels[b]};
                        history[b] = h;
                        if (h == HIST_EMPTY)
                            stable_now[b] = 1'b0;
                        else if (h == HIST_FULL)
                            stable_now[b] = 1'b1;
                    end
                    events      = events | (stable_last ^ stable_now);
                    stable_last = stable_now;
                    if (buzz_left != '0)
                    begin
                        buzz_left = buzz_left - bdel_pkg::BUZZ_W'(1);
                        if (buzz_left == '0)
                            buzz_drive = 1'b0;
                    end
                end
                bdel_pkg::OP_CONSUME:
                begin
                    want.consume_hit = |(events & it.consume_mask);
                    events = events & ~it.consume_mask;
                end
                bdel_pkg::OP_BUZZ:
                begin
                    buzz_left  = it.buzz_ms;
                    buzz_drive = (it.buzz_ms != '0);
                end
                default: ;
            endcase
            want.debounced_state = stable_now;
            want.pending_events  = events;
            want.buzzer_on       = buzz_drive;
            want.tick_count      = ticks;
            expected_results.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("debounced_state", 16'(want.debounced_state),
                          16'(got.debounced_state));
            compare_field("pending_events", 16'(want.pending_events),
                          16'(got.pending_events));
            compare_field("consume_hit", 16'(want.consume_hit), 16'(got.consume_hit));
            compare_field("buzzer_on", 16'(want.buzzer_on), 16'(got.buzzer_on));
            compare_field("tick_count", 16'(want.tick_count), 16'(got.tick_count));
        endfunction
    endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for button_debounce_event_latch: a directed opening covers reset
// state, buzzer load, reload and stop, debounce set and hold, consume hits and
// the unused op code; then random ticks that follow slowly changing button
// levels with bounce noise, mixed with consume and buzz commands. every result
// transfer is checked against a predictor fed from the accepted requests
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_BTN  = button_predict_pkg::NUM_BTN;
    localparam int HIST_LEN = button_predict_pkg::HIST_LEN;
    localparam int OP_W     = bdel_pkg::OP_W;
    localparam int BUZZ_W   = bdel_pkg::BUZZ_W;

    // number of tick, consume and buzz requests to send
    localparam int ITEM_TARGET = 1100;
    // cycles without any transfer before the run is abandoned
    localparam int IDLE_LIMIT  = 2000;
    // long receiver hold-off that fills the result register and blocks req
    localparam int HOLD_OFF    = 80;
    localparam int HOLD_AFTER  = 200;
    // cycles to watch for stray results once nothing is expected
    localparam int TAIL_CYCLES = 8;

    logic clk;
    logic rst_n;

    bdel_req_if #(.NUM_BUTTONS(NUM_BTN)) req ();
    bdel_rsp_if #(.NUM_BUTTONS(NUM_BTN)) rsp ();

    button_debounce_event_latch #(
        .NUM_BUTTONS(NUM_BTN),
        .HISTORY_LEN(HIST_LEN)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    button_predict_pkg::button_state_predictor predictor = new();

    int                 accepted_cnt = 0;
    int                 burst_left   = 0;
    logic [NUM_BTN-1:0] held_levels  = '0;

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic button_predict_pkg::req_item_t make_item(logic [OP_W-1:0] op,
                                                                logic [NUM_BTN-1:0] lv,
                                                                logic [NUM_BTN-1:0] m,
                                                                logic [BUZZ_W-1:0] ms);
        button_predict_pkg::req_item_t it;
        it.op            = op;
        it.button_levels = lv;
        it.consume_mask  = m;
        it.buzz_ms       = ms;
        return it;
    endfunction

    // button levels follow a slowly toggling held value with occasional bounce,
    // so histories mostly settle and debounced bits really change
    function automatic button_predict_pkg::req_item_t random_item();
        button_predict_pkg::req_item_t it;
        int                            r;
        it.button_levels = NUM_BTN'($urandom_range(0, 15));
        it.consume_mask  = NUM_BTN'($urandom_range(0, 15));
        it.buzz_ms       = BUZZ_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 68)
        begin
            it.op = bdel_pkg::OP_TICK;
            for (int b = 0; b < NUM_BTN; b++)
            begin
                if ($urandom_range(0, 39) == 0)
                    held_levels[b] = ~held_levels[b];
            end
            // mostly clean levels, sometimes pure noise on all buttons
            if ($urandom_range(0, 19) != 0)
            begin
                for (int b = 0; b < NUM_BTN; b++)
                begin
                    if ($urandom_range(0, 9) != 0)
                        it.button_levels[b] = held_levels[b];
                end
            end
        end
        else if (r < 82)
            it.op = bdel_pkg::OP_CONSUME;
        else if (r < 95)
        begin
            it.op = bdel_pkg::OP_BUZZ;
            // short counts so the buzzer really times out between loads
            case ($urandom_range(0, 7))
                0:       it.buzz_ms = '0;
                1:       it.buzz_ms = BUZZ_W'($urandom);
                2:       it.buzz_ms = '1;
                default: it.buzz_ms = BUZZ_W'($urandom_range(1, 30));
            endcase
        end
        else
            it.op = button_predict_pkg::OP_UNUSED;
        return it;
    endfunction

    // offer one request, with the sender idling between bursts
    task automatic offer(input button_predict_pkg::req_item_t it);
        if (burst_left == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        req.valid         <= 1'b1;
        req.op            <= it.op;
        req.button_levels <= it.button_levels;
        req.consume_mask  <= it.consume_mask;
        req.buzz_ms       <= it.buzz_ms;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        // transfer taken at this edge
        predictor.apply_request(it);
        accepted_cnt++;
    endtask

    // stimulus and end of run
    initial
    begin
        button_predict_pkg::req_item_t it;
        int                            real_items;
        real_items        = 0;
        rst_n             = 1'b0;
        req.valid         <= 1'b0;
        req.op            <= bdel_pkg::OP_TICK;
        req.button_levels <= '0;
        req.consume_mask  <= '0;
        req.buzz_ms       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        // unused op code right after reset, every field ones
        offer(make_item(button_predict_pkg::OP_UNUSED, '1, '1, '1));
        // consume with nothing latched
        offer(make_item(bdel_pkg::OP_CONSUME, '0, '1, '0));
        // longest buzz, then a reload while running
        offer(make_item(bdel_pkg::OP_BUZZ, '0, '0, '1));
        offer(make_item(bdel_pkg::OP_BUZZ, '0, '0, 16'd1));
        // eight ticks of all ones: buzzer times out, all buttons debounce high
        repeat (8)
            offer(make_item(bdel_pkg::OP_TICK, '1, '0, '0));
        // empty mask, partial mask, rest of the events, then nothing left
        offer(make_item(bdel_pkg::OP_CONSUME, '0, '0, '0));
        offer(make_item(bdel_pkg::OP_CONSUME, '0, 4'h5, '0));
        offer(make_item(bdel_pkg::OP_CONSUME, '0, '1, '0));
        offer(make_item(bdel_pkg::OP_CONSUME, '0, '1, '0));
        // buzzer stop while running
        offer(make_item(bdel_pkg::OP_BUZZ, '0, '0, 16'd3));
        offer(make_item(bdel_pkg::OP_BUZZ, '1, '1, '0));
        // a single low sample leaves the debounced state alone
        offer(make_item(bdel_pkg::OP_TICK, '0, '0, '0));
        offer(make_item(bdel_pkg::OP_TICK, 4'hA, '0, '0));
        real_items = 19;

        // random part, unused op codes do not count
        while (real_items < ITEM_TARGET)
        begin
            it = random_item();
            offer(it);
            if (it.op != button_predict_pkg::OP_UNUSED)
                real_items++;
        end
        req.valid <= 1'b0;

        while (predictor.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (predictor.mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // result checking on every rsp transfer
    initial
    begin
        button_predict_pkg::rsp_item_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                got.debounced_state = rsp.debounced_state;
                got.pending_events  = rsp.pending_events;
                got.consume_hit     = rsp.consume_hit;
                got.buzzer_on       = rsp.buzzer_on;
                got.tick_count      = rsp.tick_count;
                predictor.check_result(got);
            end
        end
    end

    // receiver: stretches of always ready, random ready and mostly stalled,
    // plus one long hold-off while requests keep coming
    initial
    begin
        int  stretch;
        int  mode;
        bit  held_off;
        held_off = 1'b0;
        rsp.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && accepted_cnt >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                rsp.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                stretch = $urandom_range(1, 40);
                mode    = $urandom_range(0, 2);
                repeat (stretch)
                begin
                    case (mode)
                        0:       rsp.ready <= 1'b1;
                        1:       rsp.ready <= ($urandom_range(0, 1) == 1);
                        default: rsp.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req.valid === 1'b1 && req.ready === 1'b1)
                       || (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_top failed");
        $finish;
    end

endmodule
